### rtl/lsi_pkg.sv
// lsi_pkg: shared types and constants of the line intersection block
// no dependencies

package lsi_pkg;

  localparam int CoordW        = 24;
  localparam int CoordFracBits = 8;
  localparam int EpsFracBits   = 16;
  localparam int EpsW          = 24;
  localparam int EpsShl        = (2 * CoordFracBits >= EpsFracBits) ?
                                 (2 * CoordFracBits - EpsFracBits) : 0;
  localparam int EpsShr        = (2 * CoordFracBits < EpsFracBits) ?
                                 (EpsFracBits - 2 * CoordFracBits) : 0;
  localparam int DiffW         = CoordW + 1;
  localparam int ProdW         = 2 * DiffW;
  localparam int DetW          = ProdW + 1;
  localparam int MagW          = DetW - 1;
  localparam int DirW          = CoordW;
  localparam int HalfW         = 25;
  localparam int PartW         = DirW + HalfW;
  localparam int RemW          = 76;
  localparam int DvsW          = MagW + 1;
  localparam int QuoW          = 27;
  localparam int CmpW          = DvsW + QuoW;
  localparam int SumW          = 28;
  localparam int CellCount     = QuoW;
  localparam int PaddrW        = 3;
  localparam int PdataW        = 32;
  localparam logic [PaddrW-1:0] AddrEpsilon = 3'd0;
  localparam logic [EpsW-1:0]   EpsReset    = 24'd16;

  typedef struct packed {
    logic signed [CoordW-1:0] ax0;
    logic signed [CoordW-1:0] ay0;
    logic signed [CoordW-1:0] ax1;
    logic signed [CoordW-1:0] ay1;
    logic signed [CoordW-1:0] bx0;
    logic signed [CoordW-1:0] by0;
    logic signed [CoordW-1:0] bx1;
    logic signed [CoordW-1:0] by1;
  } seg_t;

  typedef struct packed {
    logic signed [CoordW-1:0] base_x;
    logic signed [CoordW-1:0] base_y;
    logic                     neg_x;
    logic                     neg_y;
    logic                     par;
    logic [DvsW-1:0]          dvs;
    logic [RemW-1:0]          rem_x;
    logic [RemW-1:0]          rem_y;
    logic [QuoW-1:0]          quo_x;
    logic [QuoW-1:0]          quo_y;
  } cell_t;

endpackage

### rtl/lsi_if.sv
// lsi_in_if, lsi_out_if: request channels of the line intersection block
// depends on nothing

interface lsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] seg_a_start_x;
  logic signed [23:0] seg_a_start_y;
  logic signed [23:0] seg_a_end_x;
  logic signed [23:0] seg_a_end_y;
  logic signed [23:0] seg_b_start_x;
  logic signed [23:0] seg_b_start_y;
  logic signed [23:0] seg_b_end_x;
  logic signed [23:0] seg_b_end_y;

  modport source (
    output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    output seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    input  ready
  );
  modport sink (
    input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
    input  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
    output ready
  );
endinterface

interface lsi_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] cross_x;
  logic signed [23:0] cross_y;
  logic               lines_parallel;
  logic               result_saturated;

  modport source (
    output valid, cross_x, cross_y, lines_parallel, result_saturated,
    input  ready
  );
  modport sink (
    input  valid, cross_x, cross_y, lines_parallel, result_saturated,
    output ready
  );
endinterface

### rtl/line_segment_intersection.sv
// line_segment_intersection: top level, configuration port, divider chain
// and saturating output stage; depends on lsi_pkg, lsi_if, lsi_front, lsi_div_cell

// Takes one pair of segments per clock and returns the crossing point of
// their lines: six front stages form the determinants and the scaled
// numerators, a row of 27 cells produces one quotient bit each per cycle,
// and a final register adds the base point, saturates and holds the result.
// Throughput is one request per cycle; a stalled output fills the row before
// the input side stops. The epsilon register at byte address 0 is to be
// written only while the block is idle; the block does not enforce this.

module line_segment_intersection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsi_pkg::PaddrW-1:0]    paddr,
  input  logic [lsi_pkg::PdataW-1:0]    pwdata,
  output logic [lsi_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  lsi_in_if.sink                        seg_i,
  lsi_out_if.source                     res_o
);
  import lsi_pkg::*;

  logic [EpsW-1:0] eps_q;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrEpsilon) ? PdataW'(eps_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EpsReset;
    end else if (psel && penable && pwrite && paddr == AddrEpsilon) begin
      eps_q <= pwdata[EpsW-1:0];
    end
  end

  seg_t seg;
  assign seg.ax0 = seg_i.seg_a_start_x;
  assign seg.ay0 = seg_i.seg_a_start_y;
  assign seg.ax1 = seg_i.seg_a_end_x;
  assign seg.ay1 = seg_i.seg_a_end_y;
  assign seg.bx0 = seg_i.seg_b_start_x;
  assign seg.by0 = seg_i.seg_b_start_y;
  assign seg.bx1 = seg_i.seg_b_end_x;
  assign seg.by1 = seg_i.seg_b_end_y;

  logic [CellCount:0] cv;
  logic [CellCount:0] cr;
  cell_t              cd [CellCount+1];

  lsi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .eps_i   (eps_q),
    .valid_i (seg_i.valid),
    .ready_o (seg_i.ready),
    .seg_i   (seg),
    .valid_o (cv[0]),
    .ready_i (cr[0]),
    .data_o  (cd[0])
  );

  for (genvar g = 0; g < CellCount; g++) begin : g_cell
    lsi_div_cell #(
      .Shift (CellCount - 1 - g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .ready_o (cr[g]),
      .data_i  (cd[g]),
      .valid_o (cv[g+1]),
      .ready_i (cr[g+1]),
      .data_o  (cd[g+1])
    );
  end

  // output stage
  cell_t                    fin;
  logic                     out_valid_q;
  logic signed [CoordW-1:0] cx_q, cy_q, cx_d, cy_d;
  logic                     par_q, sat_q, sat_d;
  logic signed [SumW-1:0]   vx, vy;
  logic                     satx, saty;

  localparam logic signed [SumW-1:0] OutMax = SumW'(8388607);
  localparam logic signed [SumW-1:0] OutMin = -SumW'(8388608);

  assign fin       = cd[CellCount];
  assign cr[CellCount] = !out_valid_q || res_o.ready;

  always_comb begin
    vx = fin.neg_x ? SumW'(fin.base_x) - $signed({2'b0, fin.quo_x[QuoW-2:0]})
                   : SumW'(fin.base_x) + $signed({2'b0, fin.quo_x[QuoW-2:0]});
    vy = fin.neg_y ? SumW'(fin.base_y) - $signed({2'b0, fin.quo_y[QuoW-2:0]})
                   : SumW'(fin.base_y) + $signed({2'b0, fin.quo_y[QuoW-2:0]});
    satx = 1'b1;
    saty = 1'b1;
    if (fin.quo_x[QuoW-1]) begin
      cx_d = fin.neg_x ? OutMin[CoordW-1:0] : OutMax[CoordW-1:0];
    end else if (vx > OutMax) begin
      cx_d = OutMax[CoordW-1:0];
    end else if (vx < OutMin) begin
      cx_d = OutMin[CoordW-1:0];
    end else begin
      cx_d = vx[CoordW-1:0];
      satx = 1'b0;
    end
    if (fin.quo_y[QuoW-1]) begin
      cy_d = fin.neg_y ? OutMin[CoordW-1:0] : OutMax[CoordW-1:0];
    end else if (vy > OutMax) begin
      cy_d = OutMax[CoordW-1:0];
    end else if (vy < OutMin) begin
      cy_d = OutMin[CoordW-1:0];
    end else begin
      cy_d = vy[CoordW-1:0];
      saty = 1'b0;
    end
    sat_d = satx || saty;
    if (fin.par) begin
      cx_d  = '0;
      cy_d  = '0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cr[CellCount]) begin
      out_valid_q <= cv[CellCount];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cr[CellCount]) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      par_q <= fin.par;
      sat_q <= sat_d;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.cross_x          = cx_q;
  assign res_o.cross_y          = cy_q;
  assign res_o.lines_parallel   = par_q;
  assign res_o.result_saturated = sat_q;

endmodule

### rtl/lsi_front.sv
// lsi_front: six stage front end, differences, determinants, parallel test
// and scaled numerators for the divider chain; depends on lsi_pkg

module lsi_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [lsi_pkg::EpsW-1:0] eps_i,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  lsi_pkg::seg_t           seg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output lsi_pkg::cell_t          data_o
);
  import lsi_pkg::*;

  localparam int Stages = 6;

  logic [Stages-1:0] v_q;
  logic [Stages-1:0] load;

  always_comb begin
    load[Stages-1] = !v_q[Stages-1] || ready_i;
    for (int i = Stages - 2; i >= 0; i--) begin
      load[i] = !v_q[i] || load[i+1];
    end
  end

  assign ready_o = load[0];
  assign valid_o = v_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= valid_i;
      end
      for (int i = 1; i < Stages; i++) begin
        if (load[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // stage 1: differences
  logic signed [DiffW-1:0]  dax1_q, day1_q, dbx1_q, dby1_q, wx1_q, wy1_q;
  logic signed [CoordW-1:0] bx1_q, by1_q;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      dax1_q <= DiffW'(seg_i.ax1) - DiffW'(seg_i.ax0);
      day1_q <= DiffW'(seg_i.ay1) - DiffW'(seg_i.ay0);
      dbx1_q <= DiffW'(seg_i.bx1) - DiffW'(seg_i.bx0);
      dby1_q <= DiffW'(seg_i.by1) - DiffW'(seg_i.by0);
      wx1_q  <= DiffW'(seg_i.bx0) - DiffW'(seg_i.ax0);
      wy1_q  <= DiffW'(seg_i.by0) - DiffW'(seg_i.ay0);
      bx1_q  <= seg_i.ax0;
      by1_q  <= seg_i.ay0;
    end
  end

  // stage 2: cross products
  logic signed [ProdW-1:0]  pd0_q, pd1_q, pn0_q, pn1_q;
  logic signed [DiffW-1:0]  dax2_q, day2_q;
  logic signed [CoordW-1:0] bx2_q, by2_q;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      pd0_q  <= dax1_q * dby1_q;
      pd1_q  <= day1_q * dbx1_q;
      pn0_q  <= wx1_q * dby1_q;
      pn1_q  <= wy1_q * dbx1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      bx2_q  <= bx1_q;
      by2_q  <= by1_q;
    end
  end

  // stage 3: determinant and numerator
  logic signed [DetW-1:0]   det3_q, num3_q;
  logic signed [DiffW-1:0]  dax3_q, day3_q;
  logic signed [CoordW-1:0] bx3_q, by3_q;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      det3_q <= DetW'(pd0_q) - DetW'(pd1_q);
      num3_q <= DetW'(pn0_q) - DetW'(pn1_q);
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
    end
  end

  // stage 4: magnitudes, signs and parallel test
  logic [DetW-1:0]   det_neg, num_neg, dax_neg, day_neg;
  logic [MagW-1:0]   adet_d, anum_d;
  logic [DirW-1:0]   adx_d, ady_d;
  logic [63:0]       eps_al;
  logic              par_d;

  always_comb begin
    det_neg = -det3_q;
    num_neg = -num3_q;
    dax_neg = -DetW'(dax3_q);
    day_neg = -DetW'(day3_q);
    adet_d  = det3_q[DetW-1] ? det_neg[MagW-1:0] : det3_q[MagW-1:0];
    anum_d  = num3_q[DetW-1] ? num_neg[MagW-1:0] : num3_q[MagW-1:0];
    adx_d   = dax3_q[DiffW-1] ? dax_neg[DirW-1:0] : dax3_q[DirW-1:0];
    ady_d   = day3_q[DiffW-1] ? day_neg[DirW-1:0] : day3_q[DirW-1:0];
    eps_al  = ((64'(eps_i) + ((64'(1) << EpsShr) - 64'(1))) >> EpsShr) << EpsShl;
    par_d   = (det3_q == '0) || (64'(adet_d) < eps_al);
  end

  logic [MagW-1:0]          adet4_q, anum4_q;
  logic [DirW-1:0]          adx4_q, ady4_q;
  logic                     negx4_q, negy4_q, par4_q;
  logic signed [CoordW-1:0] bx4_q, by4_q;

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      adet4_q <= adet_d;
      anum4_q <= anum_d;
      adx4_q  <= adx_d;
      ady4_q  <= ady_d;
      negx4_q <= dax3_q[DiffW-1] ^ num3_q[DetW-1] ^ det3_q[DetW-1];
      negy4_q <= day3_q[DiffW-1] ^ num3_q[DetW-1] ^ det3_q[DetW-1];
      par4_q  <= par_d;
      bx4_q   <= bx3_q;
      by4_q   <= by3_q;
    end
  end

  // stage 5: partial products of direction times numerator
  logic [PartW-1:0]         plx5_q, phx5_q, ply5_q, phy5_q;
  logic [MagW-1:0]          adet5_q;
  logic                     negx5_q, negy5_q, par5_q;
  logic signed [CoordW-1:0] bx5_q, by5_q;

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      plx5_q  <= PartW'(adx4_q) * PartW'(anum4_q[HalfW-1:0]);
      phx5_q  <= PartW'(adx4_q) * PartW'(anum4_q[MagW-1:HalfW]);
      ply5_q  <= PartW'(ady4_q) * PartW'(anum4_q[HalfW-1:0]);
      phy5_q  <= PartW'(ady4_q) * PartW'(anum4_q[MagW-1:HalfW]);
      adet5_q <= adet4_q;
      negx5_q <= negx4_q;
      negy5_q <= negy4_q;
      par5_q  <= par4_q;
      bx5_q   <= bx4_q;
      by5_q   <= by4_q;
    end
  end

  // stage 6: rounded numerators over twice the determinant
  cell_t s6_q;

  always_ff @(posedge clk_i) begin
    if (load[5]) begin
      s6_q.base_x <= bx5_q;
      s6_q.base_y <= by5_q;
      s6_q.neg_x  <= negx5_q;
      s6_q.neg_y  <= negy5_q;
      s6_q.par    <= par5_q;
      s6_q.dvs    <= {adet5_q, 1'b0};
      s6_q.rem_x  <= (((RemW'(phx5_q) << HalfW) + RemW'(plx5_q)) << 1)
                     + RemW'(adet5_q) - RemW'(negx5_q);
      s6_q.rem_y  <= (((RemW'(phy5_q) << HalfW) + RemW'(ply5_q)) << 1)
                     + RemW'(adet5_q) - RemW'(negy5_q);
      s6_q.quo_x  <= '0;
      s6_q.quo_y  <= '0;
    end
  end

  assign data_o = s6_q;

endmodule

### rtl/lsi_div_cell.sv
// lsi_div_cell: one restoring division step for both coordinates
// depends on lsi_pkg

module lsi_div_cell #(
  parameter int Shift = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  lsi_pkg::cell_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output lsi_pkg::cell_t data_o
);
  import lsi_pkg::*;

  logic            valid_q;
  cell_t           data_q;
  cell_t           data_d;
  logic [CmpW-1:0] dsh, ext_x, ext_y, dif_x, dif_y;
  logic            geq_x, geq_y;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    dsh    = CmpW'(data_i.dvs) << Shift;
    ext_x  = CmpW'(data_i.rem_x);
    ext_y  = CmpW'(data_i.rem_y);
    dif_x  = ext_x - dsh;
    dif_y  = ext_y - dsh;
    geq_x  = ext_x >= dsh;
    geq_y  = ext_y >= dsh;
    data_d = data_i;
    if (geq_x) begin
      data_d.rem_x = dif_x[RemW-1:0];
      data_d.quo_x = data_i.quo_x | (QuoW'(1) << Shift);
    end
    if (geq_y) begin
      data_d.rem_y = dif_y[RemW-1:0];
      data_d.quo_y = data_i.quo_y | (QuoW'(1) << Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

### bench/tb_line_segment_intersection.sv
// tb_line_segment_intersection: directed and randomized check of the line crossing block
// depends on lsi_pkg, lsi_in_if, lsi_out_if and line_segment_intersection
// a class predicts each crossing point and compares it with the block's output
`timescale 1ns / 1ps

typedef struct {
  logic signed [23:0] x;
  logic signed [23:0] y;
  logic               par;
  logic               sat;
} crossing_t;

class crossing_board;
  crossing_t             pending_q[$];
  logic [lsi_pkg::EpsW-1:0] eps;
  int                    errors;

  function new();
    eps    = lsi_pkg::EpsReset;
    errors = 0;
  endfunction

  // base + floor(dir * num / den + 1/2), den nonzero
  static function automatic logic signed [127:0] round_coord(
      logic signed [127:0] base, logic signed [127:0] dir,
      logic signed [127:0] num, logic signed [127:0] den);
    logic signed [127:0] n, d, t, q;
    n = dir * num;
    d = den;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    t = 2 * n + d;
    q = t / (2 * d);
    if (t < 0 && q * (2 * d) != t) q = q - 1;
    return base + q;
  endfunction

  function automatic crossing_t predict(lsi_pkg::seg_t s);
    logic signed [127:0] ax0, ay0, dax, day, dbx, dby, wx, wy, det, num, adet, vx, vy;
    crossing_t r;
    ax0 = $signed(s.ax0);
    ay0 = $signed(s.ay0);
    dax = $signed(s.ax1) - ax0;
    day = $signed(s.ay1) - ay0;
    dbx = $signed(s.bx1) - $signed(s.bx0);
    dby = $signed(s.by1) - $signed(s.by0);
    wx  = $signed(s.bx0) - ax0;
    wy  = $signed(s.by0) - ay0;
    det = dax * dby - day * dbx;
    num = wx * dby - wy * dbx;
    adet = det < 0 ? -det : det;
    r = '{x: '0, y: '0, par: 1'b1, sat: 1'b0};
    if (det == 0 || adet < $signed({104'd0, eps})) return r;
    r.par = 1'b0;
    vx = round_coord(ax0, dax, num, det);
    vy = round_coord(ay0, day, num, det);
    if (vx > 8388607)       begin vx = 8388607;  r.sat = 1'b1; end
    else if (vx < -8388608) begin vx = -8388608; r.sat = 1'b1; end
    if (vy > 8388607)       begin vy = 8388607;  r.sat = 1'b1; end
    else if (vy < -8388608) begin vy = -8388608; r.sat = 1'b1; end
    r.x = vx[23:0];
    r.y = vy[23:0];
    return r;
  endfunction

  function void note_request(lsi_pkg::seg_t s);
    pending_q.push_back(predict(s));
  endfunction

  function void check_result(crossing_t got);
    crossing_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result x=%0d y=%0d par=%0b sat=%0b",
               $time, got.x, got.y, got.par, got.sat);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.x !== want.x) begin
      $display("%0t: cross_x expected %0d actual %0d", $time, want.x, got.x);
      errors++;
    end
    if (got.y !== want.y) begin
      $display("%0t: cross_y expected %0d actual %0d", $time, want.y, got.y);
      errors++;
    end
    if (got.par !== want.par) begin
      $display("%0t: lines_parallel expected %0b actual %0b", $time, want.par, got.par);
      errors++;
    end
    if (got.sat !== want.sat) begin
      $display("%0t: result_saturated expected %0b actual %0b", $time, want.sat, got.sat);
      errors++;
    end
  endfunction
endclass

module tb_line_segment_intersection;
  import lsi_pkg::*;

  localparam int Latency    = 40;
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int CMax = 8388607;
  localparam int CMin = -8388608;

  logic              clk_i;
  logic              rst_ni;
  logic              psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata, prdata;

  lsi_in_if  seg_if ();
  lsi_out_if res_if ();

  line_segment_intersection dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .seg_i(seg_if), .res_o(res_if)
  );

  crossing_board board = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic seg_t mk(int ax0, int ay0, int ax1, int ay1,
                              int bx0, int by0, int bx1, int by1);
    seg_t s;
    s.ax0 = ax0[23:0]; s.ay0 = ay0[23:0]; s.ax1 = ax1[23:0]; s.ay1 = ay1[23:0];
    s.bx0 = bx0[23:0]; s.by0 = by0[23:0]; s.bx1 = bx1[23:0]; s.by1 = by1[23:0];
    return s;
  endfunction

  function automatic seg_t random_pair();
    int ax, ay, dx, dy, bx, by;
    case ($urandom_range(3))
      0: return mk(rnd(CMin, CMax), rnd(CMin, CMax), rnd(CMin, CMax), rnd(CMin, CMax),
                   rnd(CMin, CMax), rnd(CMin, CMax), rnd(CMin, CMax), rnd(CMin, CMax));
      1: return mk(rnd(-4096, 4096), rnd(-4096, 4096), rnd(-4096, 4096), rnd(-4096, 4096),
                   rnd(-4096, 4096), rnd(-4096, 4096), rnd(-4096, 4096), rnd(-4096, 4096));
      default: begin
        // nearly parallel lines, crossing far away or not at all
        ax = rnd(-(1 << 20), 1 << 20);
        ay = rnd(-(1 << 20), 1 << 20);
        dx = rnd(-4096, 4096);
        dy = rnd(-4096, 4096);
        bx = rnd(-(1 << 20), 1 << 20);
        by = rnd(-(1 << 20), 1 << 20);
        return mk(ax, ay, ax + dx, ay + dy, bx, by,
                  bx + dx + rnd(-3, 3), by + dy + rnd(-3, 3));
      end
    endcase
  endfunction

  task automatic send(seg_t s);
    seg_if.valid         <= 1'b1;
    seg_if.seg_a_start_x <= s.ax0;
    seg_if.seg_a_start_y <= s.ay0;
    seg_if.seg_a_end_x   <= s.ax1;
    seg_if.seg_a_end_y   <= s.ay1;
    seg_if.seg_b_start_x <= s.bx0;
    seg_if.seg_b_start_y <= s.by0;
    seg_if.seg_b_end_x   <= s.bx1;
    seg_if.seg_b_end_y   <= s.by1;
    do @(posedge clk_i); while (!seg_if.ready);
    if (idle_on && $urandom_range(3) == 0) begin
      seg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_write(logic [EpsW-1:0] value);
    seg_if.valid <= 1'b0;
    wait (board.pending_q.size() == 0);
    repeat (Latency) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrEpsilon;
    pwdata  <= PdataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.eps = value;
  endtask

  task automatic run_directed();
    send(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(-256, 0, 256, 0, 0, -256, 0, 256));
    send(mk(CMin, CMin, CMax, CMax, CMin, CMax, CMax, CMin));
    send(mk(CMax, CMax, CMin, CMin, CMax, CMin, CMin, CMax));
    send(mk(CMax, CMin, CMin, CMax, CMin, CMin, CMax, CMax));
    send(mk(0, 0, 512, 512, 256, 256, 1024, 1024));
    send(mk(0, 0, 1, 1, 1, 0, 0, 1));
    send(mk(0, 0, -1, -1, -1, 0, 0, -1));
    send(mk(0, 0, 1, 0, 0, 1, 1, 2));
    send(mk(0, 0, 4, 0, 0, 1, 4, 2));
    send(mk(0, 0, CMax, 1, 0, 256, CMax, 258));
    send(mk(CMin, 0, CMax, 1, CMin, -256, CMax, -254));
    send(mk(0, 0, CMax, 0, 0, 0, 0, CMax));
    send(mk(CMax, CMax, CMax, CMin, CMin, CMin, CMax, CMin));
    send(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    send(mk(100, 200, 300, 700, -500, 900, 800, -300));
    send(mk(0, 0, 3, 1, 0, 0, 1, 3));
    send(mk(CMin, CMin, CMin + 1, CMin, CMin, CMin + 1, CMin + 1, CMin + 2));
  endtask

  task automatic run_random(int count);
    repeat (count) send(random_pair());
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && seg_if.valid && seg_if.ready)
      board.note_request('{ax0: seg_if.seg_a_start_x, ay0: seg_if.seg_a_start_y,
                           ax1: seg_if.seg_a_end_x,   ay1: seg_if.seg_a_end_y,
                           bx0: seg_if.seg_b_start_x, by0: seg_if.seg_b_start_y,
                           bx1: seg_if.seg_b_end_x,   by1: seg_if.seg_b_end_y});
    if (rst_ni && res_if.valid && res_if.ready)
      board.check_result('{x: res_if.cross_x, y: res_if.cross_y,
                           par: res_if.lines_parallel, sat: res_if.result_saturated});
  end

  always @(posedge clk_i) begin
    if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    seg_if.valid         = 1'b0;
    seg_if.seg_a_start_x = '0;
    seg_if.seg_a_start_y = '0;
    seg_if.seg_a_end_x   = '0;
    seg_if.seg_a_end_y   = '0;
    seg_if.seg_b_start_x = '0;
    seg_if.seg_b_start_y = '0;
    seg_if.seg_b_end_x   = '0;
    seg_if.seg_b_end_y   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(150);

    drain_and_write('0);
    run_directed();
    run_random(130);

    drain_and_write(24'hFFFFFF);
    run_directed();
    run_random(100);

    drain_and_write(EpsW'($urandom_range(32'hFFFF)));
    run_random(130);

    drain_and_write(24'd1);
    hold_req = 1'b1;
    idle_on  = 1'b0;
    run_random(80);
    idle_on  = 1'b1;
    run_random(40);
    idle_on  = 1'b0;
    run_random(70);

    seg_if.valid <= 1'b0;
    wait (board.pending_q.size() == 0);
    repeat (Latency) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
